// ----- sv/mcmp_pkg.sv -----
// mcmp_pkg: shared types and codes for the MIDI channel message parser.
// Holds the command nibbles, the event kind codes and the event struct.
// No dependencies.
package mcmp_pkg;

  localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
  localparam logic [3:0] CMD_POLY_PRESS = 4'hA;
  localparam logic [3:0] CMD_CTRL       = 4'hB;
  localparam logic [3:0] CMD_PROGRAM    = 4'hC;
  localparam logic [3:0] CMD_CHAN_PRESS = 4'hD;
  localparam logic [3:0] CMD_BEND       = 4'hE;
  localparam logic [3:0] CMD_SYSTEM     = 4'hF;

  localparam logic [7:0]  SYSEX_START   = 8'hF0;
  localparam logic [7:0]  SYSEX_END     = 8'hF7;
  localparam logic [7:0]  PRESS_MAX     = 8'h80;
  localparam logic [15:0] BEND_CENTRE   = 16'd8192;

  typedef enum logic [2:0] {
    KIND_NOTE_ON    = 3'd0,
    KIND_NOTE_OFF   = 3'd1,
    KIND_KEY_PRESS  = 3'd2,
    KIND_CHAN_PRESS = 3'd3,
    KIND_CTRL       = 3'd4,
    KIND_BEND       = 3'd5
  } kind_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [3:0]         channel;
    logic [7:0]         key;
    logic signed [15:0] value;
  } event_t;

endpackage

// ----- sv/mcmp_decode.sv -----
// mcmp_decode: parser state machine and event decode for one staged byte.
// Depends on mcmp_pkg for command codes and the event struct.
module mcmp_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  output mcmp_pkg::event_t     ev
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_D1    = 4'b0010,
    PH_D2    = 4'b0100,
    PH_SYSEX = 4'b1000
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] held_command, held_command_next;
  logic [3:0] held_channel, held_channel_next;
  logic [7:0] first_data, first_data_next;

  logic       done;
  logic [7:0] d1, d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_command <= 4'h0;
      held_channel <= 4'h0;
      first_data   <= 8'h00;
    end else if (fire) begin
      phase        <= phase_next;
      held_command <= held_command_next;
      held_channel <= held_channel_next;
      first_data   <= first_data_next;
    end
  end

  // Next state; done marks a completed message whose data is d1/d2.
  always_comb begin
    phase_next        = phase;
    held_command_next = held_command;
    held_channel_next = held_channel;
    first_data_next   = first_data;
    done              = 1'b0;
    d1                = rx_byte;
    d2                = 8'h00;
    unique case (phase)
      PH_IDLE: begin
        if (rx_byte[7]) begin
          if (rx_byte[7:4] == mcmp_pkg::CMD_SYSTEM) begin
            if (rx_byte == mcmp_pkg::SYSEX_START) phase_next = PH_SYSEX;
          end else begin
            held_command_next = rx_byte[7:4];
            held_channel_next = rx_byte[3:0];
            phase_next        = PH_D1;
          end
        end
      end
      PH_D1: begin
        if (held_command == mcmp_pkg::CMD_PROGRAM ||
            held_command == mcmp_pkg::CMD_CHAN_PRESS) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end else begin
          first_data_next = rx_byte;
          phase_next      = PH_D2;
        end
      end
      PH_D2: begin
        phase_next = PH_IDLE;
        done       = 1'b1;
        d1         = first_data;
        d2         = rx_byte;
      end
      PH_SYSEX: begin
        if (rx_byte == mcmp_pkg::SYSEX_END) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Event fields from the latched command and the data bytes
  always_comb begin
    logic emit;
    emit     = 1'b0;
    ev.kind  = mcmp_pkg::KIND_NOTE_ON;
    ev.key   = d1;
    ev.value = 16'sd0;
    unique case (held_command)
      mcmp_pkg::CMD_NOTE_ON: begin
        emit     = 1'b1;
        ev.value = {8'h00, d2};
      end
      mcmp_pkg::CMD_NOTE_OFF: begin
        emit    = 1'b1;
        ev.kind = mcmp_pkg::KIND_NOTE_OFF;
      end
      mcmp_pkg::CMD_POLY_PRESS: begin
        emit = 1'b1;
        if (d2 == 8'h00) begin
          ev.kind = mcmp_pkg::KIND_NOTE_OFF;
        end else begin
          ev.kind  = mcmp_pkg::KIND_KEY_PRESS;
          ev.value = {8'h00, d2};
        end
      end
      mcmp_pkg::CMD_CHAN_PRESS: begin
        emit     = (d1 <= mcmp_pkg::PRESS_MAX);
        ev.kind  = mcmp_pkg::KIND_CHAN_PRESS;
        ev.key   = 8'h00;
        ev.value = {8'h00, d1};
      end
      mcmp_pkg::CMD_CTRL: begin
        emit     = 1'b1;
        ev.kind  = mcmp_pkg::KIND_CTRL;
        ev.value = {d2[7], d2, 7'b0000000};
      end
      mcmp_pkg::CMD_BEND: begin
        emit     = 1'b1;
        ev.kind  = mcmp_pkg::KIND_BEND;
        ev.key   = 8'h00;
        ev.value = {1'b0, d2, 7'b0000000} + {8'h00, d1} - mcmp_pkg::BEND_CENTRE;
      end
      default: emit = 1'b0;
    endcase
    ev.channel = held_channel;
    ev.valid   = fire && done && emit;
  end

endmodule

// ----- sv/mcmp_out_reg.sv -----
// mcmp_out_reg: result register holding one decoded event for the consumer.
// Depends on mcmp_pkg for the event struct.
module mcmp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  mcmp_pkg::event_t ev,
  output logic             can_take,
  output logic             event_valid,
  input  logic             event_ready,
  output mcmp_pkg::event_t held
);

  logic full, full_next;

  assign can_take    = !full || event_ready;
  assign event_valid = full;

  always_comb begin
    full_next = full;
    if (can_take) full_next = ev.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && ev.valid) held <= ev;
  end

endmodule

// ----- sv/midi_channel_message_parser.sv -----
// MIDI channel message parser: one received byte per item in, decoded events out.
// An accepted byte is staged, then decoded into the result register (two register
// stages: input byte, result). Throughput: one byte per cycle unless held by
// a stalled result register; the decode between the stages is shallow.
// Reset (rst, synchronous): parser idle, held status and data cleared, stages empty.
// Depends on mcmp_pkg, mcmp_decode, mcmp_out_reg.
module midi_channel_message_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               event_valid,
  input  logic               event_ready,
  output logic [2:0]         event_kind,
  output logic [3:0]         midi_channel,
  output logic [7:0]         key_or_control,
  output logic signed [15:0] event_value
);

  // Input stage: one staged byte waiting to be parsed
  logic       stage_valid, stage_valid_next;
  logic [7:0] stage_byte;

  logic             can_take;
  logic             fire;
  mcmp_pkg::event_t ev;
  mcmp_pkg::event_t held;

  // The staged byte is parsed only when the result register can take its
  // event, so parser state never runs ahead of a stalled result.
  assign fire     = stage_valid && can_take;
  assign rx_ready = !stage_valid || fire;

  always_comb begin
    stage_valid_next = stage_valid;
    if (rx_ready) stage_valid_next = rx_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) stage_byte <= rx_byte;
  end

  // Parser state machine and event decode
  mcmp_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (stage_byte),
    .ev      (ev)
  );

  // Result register; it frees itself in the same cycle it is taken
  mcmp_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .can_take    (can_take),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .held        (held)
  );

  assign event_kind     = held.kind;
  assign midi_channel   = held.channel;
  assign key_or_control = held.key;
  assign event_value    = held.value;

endmodule
